// File: design/hrp_pkg.sv
// Shared types and constants for the HTTP response header parser.
package hrp_pkg;

  localparam int DataW   = 8;
  localparam int HdrCntW = 16;
  localparam int LenW    = 24;
  localparam int StatusW = 31;
  localparam int KindW   = 2;
  localparam int ErrW    = 4;
  localparam int CfgIdxW = 2;

  localparam logic [HdrCntW-1:0] MAX_HEADER_RESET = 16'd32768;
  localparam logic [LenW-1:0]    MAX_BODY_RESET   = 24'd10485760;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_HEADER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BODY   = 2'd1;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_BODY  = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [ErrW-1:0] ERR_NONE       = 4'd0;
  localparam logic [ErrW-1:0] ERR_HDR_BIG    = 4'd1;
  localparam logic [ErrW-1:0] ERR_NO_SPACE   = 4'd2;
  localparam logic [ErrW-1:0] ERR_BAD_STATUS = 4'd3;
  localparam logic [ErrW-1:0] ERR_NO_COLON   = 4'd4;
  localparam logic [ErrW-1:0] ERR_EMPTY_KEY  = 4'd5;
  localparam logic [ErrW-1:0] ERR_BAD_LEN    = 4'd6;
  localparam logic [ErrW-1:0] ERR_LEN_BIG    = 4'd7;
  localparam logic [ErrW-1:0] ERR_CLOSED     = 4'd8;

  // One result beat.
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [DataW-1:0]   body;
    logic               last;
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    clen;
    logic [ErrW-1:0]    err;
  } result_t;

endpackage

// File: design/http_response_header_parser.sv
// Each result beat is registered on the output register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty; the byte engine and output register are single-pass.
// A skid entry behind the output register takes one more beat while the output stalls.
// Reset (synchronous, active high) returns to the status line and loads register defaults.
// After completion or failure the block produces nothing further until reset.
module http_response_header_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hrp_pkg::DataW-1:0]    data_byte,
  input  logic                         peer_closed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hrp_pkg::KindW-1:0]    result_kind,
  output logic [hrp_pkg::DataW-1:0]    body_byte,
  output logic                         last,
  output logic [hrp_pkg::StatusW-1:0]  status_code,
  output logic [hrp_pkg::LenW-1:0]     content_length,
  output logic [hrp_pkg::ErrW-1:0]     error_code,
  input  logic                         cfg_we,
  input  logic [hrp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hrp_pkg::LenW-1:0]     cfg_data
);
  import hrp_pkg::*;

  logic [HdrCntW-1:0] max_header;
  logic [LenW-1:0]    max_body;
  logic               in_fire;
  logic               res_valid;
  result_t            res;
  result_t            out_q, skid_q;
  logic               skid_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_header <= MAX_HEADER_RESET;
      max_body   <= MAX_BODY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_HEADER: max_header <= cfg_data[HdrCntW-1:0];
        CFG_MAX_BODY:   max_body   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;

  hrp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .data_byte   (data_byte),
    .peer_closed (peer_closed),
    .max_header  (max_header),
    .max_body    (max_body),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign result_kind    = out_q.kind;
  assign body_byte      = out_q.body;
  assign last           = out_q.last;
  assign status_code    = out_q.status;
  assign content_length = out_q.clen;
  assign error_code     = out_q.err;

  // The skid entry fills only behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output beat");

  // A skid beat moves to the output when the output drains.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> out_valid && !skid_valid)
    else $error("skid entry not drained");

  // No input is taken while the skid entry is full.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && $stable(skid_q))
    else $error("skid entry overwritten");

endmodule

// File: design/hrp_core.sv
// Byte-wide parse engine: status line, header lines, terminator and body count.
module hrp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic [hrp_pkg::DataW-1:0]   data_byte,
  input  logic                        peer_closed,
  input  logic [hrp_pkg::HdrCntW-1:0] max_header,
  input  logic [hrp_pkg::LenW-1:0]    max_body,
  output logic                        res_valid,
  output hrp_pkg::result_t            res
);
  import hrp_pkg::*;

  typedef enum logic [2:0] {
    PH_STATUS, PH_HEADERS, PH_BODY, PH_DONE, PH_FAILED
  } phase_t;

  // Line positions within a header line.
  localparam logic [2:0] LP_START      = 3'd0;
  localparam logic [2:0] LP_KEY        = 3'd1;
  localparam logic [2:0] LP_KEY_TRAIL  = 3'd2;
  localparam logic [2:0] LP_VAL_LEAD   = 3'd3;
  localparam logic [2:0] LP_VAL_DIGITS = 3'd4;
  localparam logic [2:0] LP_VAL_TRAIL  = 3'd5;
  localparam logic [2:0] LP_SKIP       = 3'd6;

  localparam logic [3:0] KEY_LEN  = 4'd14;
  localparam logic [3:0] KEY_MISS = 4'd15;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [StatusW-1:0] status_acc;
    logic               status_ovf;
    logic [1:0]         field_pos;
    logic [2:0]         line_pos;
    logic [3:0]         key_idx;
    logic               key_nonempty;
    logic               len_found;
    logic [LenW-1:0]    len_acc;
    logic               len_invalid;
    logic               len_big;
    logic [ErrW-1:0]    err;
  } ctx_t;

  function automatic logic [7:0] key_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:  c = "c";
      4'd1:  c = "o";
      4'd2:  c = "n";
      4'd3:  c = "t";
      4'd4:  c = "e";
      4'd5:  c = "n";
      4'd6:  c = "t";
      4'd7:  c = "-";
      4'd8:  c = "l";
      4'd9:  c = "e";
      4'd10: c = "n";
      4'd11: c = "g";
      4'd12: c = "t";
      4'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic ctx_t latch_err(input ctx_t s, input logic [ErrW-1:0] e);
    ctx_t t;
    t = s;
    if (t.err == ERR_NONE) t.err = e;
    return t;
  endfunction

  // One character of the status line or of a header line.
  function automatic ctx_t feed(input ctx_t s, input logic in_status, input logic [7:0] c);
    ctx_t t;
    logic [StatusW+3:0] sv;
    logic [LenW+3:0]    lv;
    logic [3:0]         d;
    t  = s;
    d  = c[3:0] - 4'd0;
    sv = ({4'd0, s.status_acc} << 3) + ({4'd0, s.status_acc} << 1) + {{(StatusW){1'b0}}, d};
    lv = ({4'd0, s.len_acc} << 3) + ({4'd0, s.len_acc} << 1) + {{(LenW){1'b0}}, d};
    if (in_status) begin
      if (s.field_pos == 2'd0) begin
        if (c == CH_SP) t.field_pos = 2'd1;
      end else if (s.field_pos != 2'd3) begin
        if (c == CH_SP) begin
          if (s.field_pos == 2'd1) t = latch_err(t, ERR_BAD_STATUS);
          t.field_pos = 2'd3;
        end else if (is_digit(c)) begin
          if (!s.status_ovf) begin
            if (sv > {4'd0, {StatusW{1'b1}}}) begin
              t.status_ovf = 1'b1;
              t = latch_err(t, ERR_BAD_STATUS);
            end else begin
              t.status_acc = sv[StatusW-1:0];
            end
          end
          t.field_pos = 2'd2;
        end else begin
          t = latch_err(t, ERR_BAD_STATUS);
          t.field_pos = 2'd2;
        end
      end
    end else begin
      case (s.line_pos)
        LP_START, LP_KEY, LP_KEY_TRAIL: begin
          if (c == CH_COLON) begin
            if (!s.key_nonempty) begin
              t = latch_err(t, ERR_EMPTY_KEY);
              t.line_pos = LP_SKIP;
            end else if (s.key_idx == KEY_LEN && !s.len_found) begin
              t.len_found = 1'b1;
              t.line_pos  = LP_VAL_LEAD;
            end else begin
              t.line_pos = LP_SKIP;
            end
          end else if (is_ws(c)) begin
            t.line_pos = s.key_nonempty ? LP_KEY_TRAIL : LP_KEY;
          end else begin
            if (s.line_pos == LP_KEY_TRAIL) t.key_idx = KEY_MISS;
            else if (s.key_idx < KEY_LEN && to_lower(c) == key_char(s.key_idx))
              t.key_idx = s.key_idx + 4'd1;
            else t.key_idx = KEY_MISS;
            t.key_nonempty = 1'b1;
            t.line_pos     = LP_KEY;
          end
        end
        LP_VAL_LEAD, LP_VAL_DIGITS: begin
          if (is_digit(c)) begin
            if (!s.len_big) begin
              if (lv > {4'd0, {LenW{1'b1}}}) begin
                t.len_big = 1'b1;
                t.len_acc = {LenW{1'b1}};
              end else begin
                t.len_acc = lv[LenW-1:0];
              end
            end
            t.line_pos = LP_VAL_DIGITS;
          end else if (is_ws(c)) begin
            t.line_pos = (s.line_pos == LP_VAL_LEAD) ? LP_VAL_LEAD : LP_VAL_TRAIL;
          end else begin
            t.len_invalid = 1'b1;
            t.line_pos    = LP_SKIP;
          end
        end
        LP_VAL_TRAIL: begin
          if (!is_ws(c)) begin
            t.len_invalid = 1'b1;
            t.line_pos    = LP_SKIP;
          end
        end
        default: ;
      endcase
    end
    return t;
  endfunction

  // Close the current line.
  function automatic ctx_t end_line(input ctx_t s, input logic in_status);
    ctx_t t;
    t = s;
    if (in_status) begin
      if (s.field_pos == 2'd0) t = latch_err(t, ERR_NO_SPACE);
      else if (s.field_pos == 2'd1) t = latch_err(t, ERR_BAD_STATUS);
    end else begin
      if (s.line_pos == LP_KEY || s.line_pos == LP_KEY_TRAIL) t = latch_err(t, ERR_NO_COLON);
      else if (s.line_pos == LP_VAL_LEAD) t.len_invalid = 1'b1;
    end
    t.line_pos     = LP_START;
    t.key_idx      = 4'd0;
    t.key_nonempty = 1'b0;
    return t;
  endfunction

  phase_t              phase, phase_next;
  ctx_t                ctx, ctx_next;
  logic [1:0]          prog, prog_next;
  logic [HdrCntW-1:0]  hdr_cnt, hdr_cnt_next;
  logic [LenW-1:0]     remaining, remaining_next;
  logic                emit;
  logic [KindW-1:0]    emit_kind;
  logic [ErrW-1:0]     emit_err;
  logic                emit_last;

  // Next-state and result for the accepted byte.
  always_comb begin
    ctx_t            t;
    logic            in_status;
    logic [ErrW-1:0] e;
    phase_next     = phase;
    ctx_next       = ctx;
    prog_next      = prog;
    hdr_cnt_next   = hdr_cnt;
    remaining_next = remaining;
    emit           = 1'b0;
    emit_kind      = KIND_BODY;
    emit_err       = ERR_NONE;
    emit_last      = 1'b0;
    in_status      = (phase == PH_STATUS);
    t              = ctx;
    e              = ERR_NONE;
    if (in_fire && phase != PH_DONE && phase != PH_FAILED) begin
      if (peer_closed) begin
        phase_next = PH_FAILED;
        emit       = 1'b1;
        emit_kind  = KIND_ERROR;
        emit_err   = ERR_CLOSED;
      end else if (phase == PH_BODY) begin
        remaining_next = remaining - 1'b1;
        emit           = 1'b1;
        emit_last      = (remaining_next == '0);
        if (emit_last) phase_next = PH_DONE;
      end else if (prog == 2'd3 && data_byte == CH_LF) begin
        // Header terminator complete.
        prog_next = 2'd0;
        e         = ctx.err;
        t         = end_line(ctx, in_status);
        if (e == ERR_NONE) e = t.err;
        if (e == ERR_NONE && t.len_found) begin
          if (t.len_invalid) e = ERR_BAD_LEN;
          else if (t.len_big || t.len_acc > max_body) e = ERR_LEN_BIG;
        end
        ctx_next = t;
        if (e != ERR_NONE) begin
          phase_next = PH_FAILED;
          emit       = 1'b1;
          emit_kind  = KIND_ERROR;
          emit_err   = e;
        end else if (t.len_acc == '0) begin
          phase_next = PH_DONE;
          emit       = 1'b1;
          emit_kind  = KIND_EMPTY;
        end else begin
          remaining_next = t.len_acc;
          phase_next     = PH_BODY;
        end
      end else begin
        if (prog[0] && data_byte == CH_LF) begin
          t          = end_line(ctx, in_status);
          phase_next = PH_HEADERS;
          prog_next  = 2'd2;
        end else begin
          // A held-back CR that is not followed by LF is a plain character.
          if (prog[0]) t = feed(t, in_status, CH_CR);
          if (data_byte == CH_CR) begin
            prog_next = (prog == 2'd2) ? 2'd3 : 2'd1;
          end else begin
            t         = feed(t, in_status, data_byte);
            prog_next = 2'd0;
          end
        end
        ctx_next = t;
        if (hdr_cnt >= max_header) begin
          phase_next = PH_FAILED;
          emit       = 1'b1;
          emit_kind  = KIND_ERROR;
          emit_err   = ERR_HDR_BIG;
        end else begin
          hdr_cnt_next = hdr_cnt + 1'b1;
        end
      end
    end
  end

  // Result fields follow the updated context.
  always_comb begin
    logic ok;
    ok         = (emit_kind != KIND_ERROR);
    res_valid  = emit;
    res.kind   = emit_kind;
    res.body   = (emit_kind == KIND_BODY) ? data_byte : '0;
    res.last   = emit_last;
    res.status = ok ? ctx_next.status_acc : '0;
    res.clen   = ok ? ctx_next.len_acc : '0;
    res.err    = emit_err;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_STATUS;
      ctx       <= '0;
      prog      <= 2'd0;
      hdr_cnt   <= '0;
      remaining <= '0;
    end else begin
      phase     <= phase_next;
      ctx       <= ctx_next;
      prog      <= prog_next;
      hdr_cnt   <= hdr_cnt_next;
      remaining <= remaining_next;
    end
  end

  // Any result that ends the response leaves the engine quiet afterwards.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind != KIND_BODY || res.last) |=> !res_valid)
    else $error("result after end of response");

  // Errors carry a code and successes do not.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.kind == KIND_ERROR) == (res.err != ERR_NONE)))
    else $error("error code does not match result kind");

  // Body bytes count down only inside the body phase.
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> remaining != '0)
    else $error("body phase with nothing remaining");

endmodule

// File: test/hrp_response_checker.sv
// Checker that predicts the parser's result beats and compares them with the output channel.
`timescale 1ns / 100ps

module hrp_response_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [hrp_pkg::DataW-1:0]    data_byte,
  input  logic                         peer_closed,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [hrp_pkg::KindW-1:0]    result_kind,
  input  logic [hrp_pkg::DataW-1:0]    body_byte,
  input  logic                         last,
  input  logic [hrp_pkg::StatusW-1:0]  status_code,
  input  logic [hrp_pkg::LenW-1:0]     content_length,
  input  logic [hrp_pkg::ErrW-1:0]     error_code,
  input  logic                         cfg_we,
  input  logic [hrp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hrp_pkg::LenW-1:0]     cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import hrp_pkg::*;

  typedef enum logic [2:0] {
    PH_STATUS, PH_HEADERS, PH_BODY, PH_DONE, PH_FAILED
  } phase_t;

  typedef enum logic [2:0] {
    LP_START, LP_KEY, LP_KEY_TRAIL, LP_VAL_LEAD, LP_VAL_DIGITS, LP_VAL_TRAIL, LP_SKIP
  } line_pos_t;

  localparam int          KEY_LEN   = 14;
  localparam logic [3:0]  KEY_MISS  = 4'd15;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam string       LEN_KEY   = "content-length";

  result_t           expected_beats[$];
  logic [HdrCntW-1:0] max_hdr;
  logic [LenW-1:0]    max_body;
  phase_t             phase;
  line_pos_t          lpos;
  logic [1:0]         crlf;
  logic [HdrCntW-1:0] hdr_count;
  logic [StatusW-1:0] status_acc;
  logic               status_ovf;
  logic [1:0]         status_pos;
  logic [3:0]         key_idx;
  logic               key_seen;
  logic               len_found;
  logic [LenW-1:0]    len_acc;
  logic               len_bad;
  logic               len_huge;
  logic [ErrW-1:0]    first_err;
  logic [LenW-1:0]    body_left;

  assign pending = expected_beats.size();

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task clear_state();
    max_hdr = MAX_HEADER_RESET;
    max_body = MAX_BODY_RESET;
    phase = PH_STATUS;
    lpos = LP_START;
    crlf = '0;
    hdr_count = '0;
    status_acc = '0;
    status_ovf = 1'b0;
    status_pos = '0;
    key_idx = '0;
    key_seen = 1'b0;
    len_found = 1'b0;
    len_acc = '0;
    len_bad = 1'b0;
    len_huge = 1'b0;
    first_err = ERR_NONE;
    body_left = '0;
    expected_beats.delete();
  endtask

  task note_err(logic [ErrW-1:0] e);
    if (first_err == ERR_NONE) first_err = e;
  endtask

  task push_result(logic [KindW-1:0] kind, logic [7:0] b, logic lst, logic [ErrW-1:0] e);
    result_t r;
    r.kind = kind;
    r.body = b;
    r.last = lst;
    r.status = (kind != KIND_ERROR) ? status_acc : '0;
    r.clen = (kind != KIND_ERROR) ? len_acc : '0;
    r.err = e;
    expected_beats.push_back(r);
  endtask

  // Status line: the code sits between the first and second space.
  task status_char(logic [7:0] c);
    longint v;
    if (status_pos == 2'd0) begin
      if (c == " ") status_pos = 2'd1;
    end else if (status_pos != 2'd3) begin
      if (c == " ") begin
        if (status_pos == 2'd1) note_err(ERR_BAD_STATUS);
        status_pos = 2'd3;
      end else if (is_num(c)) begin
        if (!status_ovf) begin
          v = longint'(status_acc) * 10 + longint'(c - "0");
          if (v > 64'h7FFF_FFFF) begin
            status_ovf = 1'b1;
            note_err(ERR_BAD_STATUS);
          end else begin
            status_acc = v[StatusW-1:0];
          end
        end
        status_pos = 2'd2;
      end else begin
        note_err(ERR_BAD_STATUS);
        status_pos = 2'd2;
      end
    end
  endtask

  // Header line: key match, colon, and the length value of the first matching key.
  task header_char(logic [7:0] c);
    longint v;
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (lpos inside {LP_START, LP_KEY, LP_KEY_TRAIL}) begin
      if (c == ":") begin
        if (!key_seen) begin
          note_err(ERR_EMPTY_KEY);
          lpos = LP_SKIP;
        end else if (key_idx == KEY_LEN && !len_found) begin
          len_found = 1'b1;
          lpos = LP_VAL_LEAD;
        end else begin
          lpos = LP_SKIP;
        end
      end else if (is_space(c)) begin
        lpos = key_seen ? LP_KEY_TRAIL : LP_KEY;
      end else begin
        if (lpos == LP_KEY_TRAIL) key_idx = KEY_MISS;
        else if (key_idx < KEY_LEN && lc == LEN_KEY[key_idx]) key_idx++;
        else key_idx = KEY_MISS;
        key_seen = 1'b1;
        lpos = LP_KEY;
      end
    end else if (lpos == LP_VAL_LEAD || lpos == LP_VAL_DIGITS) begin
      if (is_num(c)) begin
        if (!len_huge) begin
          v = longint'(len_acc) * 10 + longint'(c - "0");
          if (v > 64'hFF_FFFF) begin
            len_huge = 1'b1;
            len_acc = '1;
          end else begin
            len_acc = v[LenW-1:0];
          end
        end
        lpos = LP_VAL_DIGITS;
      end else if (is_space(c)) begin
        lpos = (lpos == LP_VAL_LEAD) ? LP_VAL_LEAD : LP_VAL_TRAIL;
      end else begin
        len_bad = 1'b1;
        lpos = LP_SKIP;
      end
    end else if (lpos == LP_VAL_TRAIL) begin
      if (!is_space(c)) begin
        len_bad = 1'b1;
        lpos = LP_SKIP;
      end
    end
  endtask

  task line_char(logic [7:0] c);
    if (phase == PH_STATUS) status_char(c);
    else header_char(c);
  endtask

  task close_line();
    if (phase == PH_STATUS) begin
      if (status_pos == 2'd0) note_err(ERR_NO_SPACE);
      else if (status_pos == 2'd1) note_err(ERR_BAD_STATUS);
      phase = PH_HEADERS;
    end else begin
      if (lpos == LP_KEY || lpos == LP_KEY_TRAIL) note_err(ERR_NO_COLON);
      else if (lpos == LP_VAL_LEAD) len_bad = 1'b1;
    end
    lpos = LP_START;
    key_idx = '0;
    key_seen = 1'b0;
  endtask

  // The header terminator: report any error, else start the body or complete.
  task close_header();
    logic [ErrW-1:0] e;
    e = first_err;
    close_line();
    if (e == ERR_NONE) e = first_err;
    if (e == ERR_NONE && len_found) begin
      if (len_bad) e = ERR_BAD_LEN;
      else if (len_huge || len_acc > max_body) e = ERR_LEN_BIG;
    end
    if (e != ERR_NONE) begin
      phase = PH_FAILED;
      push_result(KIND_ERROR, '0, 1'b0, e);
    end else if (len_acc == '0) begin
      phase = PH_DONE;
      push_result(KIND_EMPTY, '0, 1'b0, ERR_NONE);
    end else begin
      body_left = len_acc;
      phase = PH_BODY;
    end
  endtask

  // Predict the result of one accepted input beat.
  task parse_byte(logic [7:0] b, logic closed);
    logic [1:0] prog;
    prog = crlf;
    if (phase == PH_DONE || phase == PH_FAILED) return;
    if (closed) begin
      phase = PH_FAILED;
      push_result(KIND_ERROR, '0, 1'b0, ERR_CLOSED);
      return;
    end
    if (phase == PH_BODY) begin
      body_left = body_left - 1'b1;
      if (body_left == '0) phase = PH_DONE;
      push_result(KIND_BODY, b, body_left == '0, ERR_NONE);
      return;
    end
    if (prog[0] && b == CH_LF) begin
      if (prog == 2'd3) begin
        crlf = '0;
        close_header();
        return;
      end
      close_line();
      crlf = 2'd2;
    end else begin
      // A held-back CR that no LF followed is an ordinary character.
      if (prog[0]) line_char(CH_CR);
      if (b == CH_CR) begin
        crlf = (prog == 2'd2) ? 2'd3 : 2'd1;
      end else begin
        line_char(b);
        crlf = '0;
      end
    end
    if (hdr_count >= max_hdr) begin
      phase = PH_FAILED;
      push_result(KIND_ERROR, '0, 1'b0, ERR_HDR_BIG);
      return;
    end
    hdr_count++;
  endtask

  task compare_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      clear_state();
    end else begin
      // Compare the output beat first; its expectation was made at an earlier edge.
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: kind %0d", result_kind);
          fail_count++;
        end else begin
          exp_r = expected_beats.pop_front();
          compare_field("result_kind", exp_r.kind, result_kind);
          compare_field("body_byte", exp_r.body, body_byte);
          compare_field("last", exp_r.last, last);
          compare_field("status_code", exp_r.status, status_code);
          compare_field("content_length", exp_r.clen, content_length);
          compare_field("error_code", exp_r.err, error_code);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_HEADER) max_hdr = cfg_data[HdrCntW-1:0];
        else if (cfg_index == CFG_MAX_BODY) max_body = cfg_data;
      end
      if (in_valid && !in_stall) parse_byte(data_byte, peer_closed);
    end
  end

endmodule

// File: test/tb.sv
// Testbench top for the HTTP response header parser: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;
  import hrp_pkg::*;

  localparam int BODY_LEN = 300;
  localparam int HOLD_CYCLES = 80;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [DataW-1:0]    data_byte;
  logic                peer_closed;
  logic                out_valid;
  logic                out_stall;
  logic [KindW-1:0]    result_kind;
  logic [DataW-1:0]    body_byte;
  logic                last;
  logic [StatusW-1:0]  status_code;
  logic [LenW-1:0]     content_length;
  logic [ErrW-1:0]     error_code;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [LenW-1:0]     cfg_data;
  int                  fail_count;
  int                  pending;
  bit                  hold_request;
  bit                  sender_burst;
  bit                  receiver_burst;
  int                  bytes_sent;

  http_response_header_parser u_dut (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .peer_closed,
    .out_valid, .out_stall, .result_kind, .body_byte, .last,
    .status_code, .content_length, .error_code,
    .cfg_we, .cfg_index, .cfg_data
  );

  hrp_response_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .peer_closed,
    .out_valid, .out_stall, .result_kind, .body_byte, .last,
    .status_code, .content_length, .error_code,
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one beat after a random gap and hold it until it is taken.
  // Valid stays high after the beat so that a zero gap gives back-to-back beats.
  task send_beat(logic [7:0] b, logic closed);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    peer_closed <= closed;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_text(string s);
    foreach (s[i]) send_beat(s[i], 1'b0);
  endtask

  task write_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop sending and wait for the block to drain before a register write.
  task settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(posedge clk);
  endtask

  // Receiver: random stall per beat, with a long hold-off on request.
  initial begin
    int wait_n;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      wait_n = receiver_burst ? 0 : $urandom_range(0, 9);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    in_valid = 1'b0;
    data_byte = '0;
    peer_closed = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_HEADER;
    cfg_data = '0;
    bytes_sent = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Both registers through low and high values, leaving a roomy header limit.
    write_reg(CFG_MAX_HEADER, 24'd4);
    write_reg(CFG_MAX_BODY, 24'd0);
    write_reg(CFG_MAX_HEADER, 24'd65535);
    write_reg(CFG_MAX_BODY, 24'hFF_FFFF);
    write_reg(CFG_MAX_HEADER, 24'd2000);

    // Directed header: lone CR, trailing key space, first matching length key wins.
    send_text("HTTP/1.1 200 OK\r\n");
    settle();
    write_reg(CFG_MAX_BODY, 24'd0);
    send_text("X-Trace: a\rb\r\n");
    send_text("Host \t:  example \r\n");
    settle();
    write_reg(CFG_MAX_BODY, LenW'(BODY_LEN));
    send_text($sformatf("CONTENT-length: \t %0d \r\n", BODY_LEN));
    send_text("content-Length: junk\r\n\r\n");

    // Body with random content, bursts and one long receiver hold-off.
    for (int i = 0; i < BODY_LEN; i++) begin
      if (i % 50 == 0) begin
        sender_burst = ($urandom_range(0, 2) == 0);
        receiver_burst = ($urandom_range(0, 2) == 0);
      end
      if (i == 120) begin
        sender_burst = 1'b1;
        hold_request = 1'b1;
      end
      if (i == 260) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      send_beat(8'($urandom_range(0, 255)), 1'b0);
    end

    // After completion the block stays silent, even for a close.
    sender_burst = 1'b0;
    send_beat(8'($urandom_range(0, 255)), 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d beats: status line and header checks, one %0d-byte body", bytes_sent,
             BODY_LEN);
    $display("with random idling, a long output hold-off and silent beats after completion.");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
